// ===== sv/pakcrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pakcrc_pkg
// Shared constants, types and the CRC-8 byte update for the pak access block.
// ----------------------------------------------------------------------------
package pakcrc_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 32;

  localparam logic [15:0] ADDR_MASK = 16'hFFE0;
  localparam logic [15:0] FILL_LOW  = 16'h8000;
  localparam logic [15:0] FILL_HIGH = 16'h9000;
  localparam logic [7:0]  FILL_BYTE = 8'h80;
  localparam logic [7:0]  CRC_POLY  = 8'h85;

  localparam logic        RAW_PAK_MODE_RST     = 1'b1;
  localparam logic        RUMBLE_AVAILABLE_RST = 1'b1;
  localparam logic [15:0] RUMBLE_ADDRESS_RST   = 16'hC000;

  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RAW_PAK_MODE     = 2'd0,
    REG_RUMBLE_AVAILABLE = 2'd1,
    REG_RUMBLE_ADDRESS   = 2'd2
  } cfg_reg_t;

  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic       rumble_on;
    logic       block_end;
    logic       crc_valid;
    logic [7:0] crc_value;
    logic [7:0] data_out;
  } result_t;

  // MSB-first CRC-8, one byte per call
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] r;
    r = crc ^ din;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/controller_pak_access_crc_top.sv =====
// Each accepted item's result is registered before it reaches the master side.
// Throughput: one item per cycle while the skid register is empty; the
// byte-parallel CRC-8 update is the longest path. A two-entry output (result
// register plus skid register) keeps s_tready high while a single result waits.
// Reset (rst, synchronous): block position and CRC cleared, rumble off,
// configuration back to raw mode, rumble available, address 0xC000.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// controller_pak_access_crc_top
// Accessory-pak byte responder: fill/echo data, rumble switch, block CRC-8.
// ----------------------------------------------------------------------------
module controller_pak_access_crc_top #(
  parameter int unsigned BLOCK_BYTES = pakcrc_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_en,
  input  wire logic [pakcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                       cfg_data,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [23:0]                       s_tdata,  // pak_address, data_byte
  input  wire logic                              s_tuser,  // req_type
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [23:0]                       m_tdata,  // data_out, crc_value, rumble_on, pad
  output      logic                              m_tuser,  // crc_valid
  output      logic                              m_tlast   // block_end
);

  localparam int unsigned POS_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);

  // configuration
  logic        raw_pak_mode;
  logic        rumble_available;
  logic [15:0] rumble_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_pak_mode     <= pakcrc_pkg::RAW_PAK_MODE_RST;
      rumble_available <= pakcrc_pkg::RUMBLE_AVAILABLE_RST;
      rumble_address   <= pakcrc_pkg::RUMBLE_ADDRESS_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        pakcrc_pkg::REG_RAW_PAK_MODE:     raw_pak_mode     <= cfg_data[0];
        pakcrc_pkg::REG_RUMBLE_AVAILABLE: rumble_available <= cfg_data[0];
        pakcrc_pkg::REG_RUMBLE_ADDRESS:   rumble_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-item logic
  logic [15:0]      addr;
  logic [7:0]       data_byte;
  logic             is_write;
  logic [7:0]       data_sel;
  logic             last;
  logic [7:0]       crc;
  logic [7:0]       crc_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             rumble;
  logic             rumble_next;
  pakcrc_pkg::result_t res;
  pakcrc_pkg::result_t out_reg;
  pakcrc_pkg::result_t skid_reg;
  logic             skid_valid;
  logic             in_fire;

  assign addr      = s_tdata[15:0] & pakcrc_pkg::ADDR_MASK;
  assign data_byte = s_tdata[23:16];
  assign is_write  = (s_tuser == pakcrc_pkg::REQ_WRITE);

  always_comb begin
    if (raw_pak_mode && !is_write) begin
      data_sel = (addr >= pakcrc_pkg::FILL_LOW && addr < pakcrc_pkg::FILL_HIGH) ?
                 pakcrc_pkg::FILL_BYTE : 8'h00;
    end else begin
      data_sel = data_byte;
    end
  end

  always_comb begin
    rumble_next = rumble;
    if (raw_pak_mode && is_write && pos == '0 && rumble_available &&
        addr == rumble_address) begin
      rumble_next = (data_byte != 8'h00);
    end
  end

  assign last     = (pos == POS_LAST);
  assign crc_next = pakcrc_pkg::crc8_update(crc, data_sel);
  assign pos_next = last ? '0 : pos + POS_W'(1);

  always_comb begin
    res.data_out  = data_sel;
    res.crc_value = (last && raw_pak_mode) ? crc_next : 8'h00;
    res.crc_valid = last && raw_pak_mode;
    res.block_end = last;
    res.rumble_on = rumble_next;
  end

  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc    <= '0;
      pos    <= '0;
      rumble <= 1'b0;
    end else if (in_fire) begin
      crc    <= last ? 8'h00 : crc_next;
      pos    <= pos_next;
      rumble <= rumble_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_reg <= skid_reg;
      end
    end else if (in_fire) begin
      if (!m_tvalid || m_tready) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end
  end

  assign m_tdata = {7'b0, out_reg.rumble_on, out_reg.crc_value, out_reg.data_out};
  assign m_tuser = out_reg.crc_valid;
  assign m_tlast = out_reg.block_end;

  a_skid_implies_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held without a pending result");

  a_crc_only_at_end : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("crc flagged on a non-final item");

  a_block_restart : assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> (pos == '0 && crc == 8'h00))
    else $error("block state not cleared after final item");

  a_skid_holds : assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> (skid_valid && $stable(skid_reg)))
    else $error("skid entry lost while output stalled");

endmodule
`default_nettype wire
